FILE: rtl/ptt_pkg.sv
package ptt_pkg;

    // Default table size
    localparam int NUM_SLOTS_DEF = 16;

    // Datapath width of period and elapsed counts
    localparam int DATA_W = 32;

    // Most results one tick may report
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    // Operation codes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_REGISTER = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CAPACITY  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [DATA_W-1:0] tick_delta;
        logic [DATA_W-1:0] task_period;
        logic [3:0]        slot_id;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_index;
        logic       fired;
        logic       last;
    } rsp_item_t;

    // One stored slot: period and elapsed count
    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] accum;
    } slot_entry_t;

    // Remainder unit result
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] remainder;
    } rem_rsp_t;

endpackage

FILE: rtl/ptt_cmd_if.sv
interface ptt_cmd_if;

    logic                  valid;
    logic                  ready;
    ptt_pkg::cmd_item_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/ptt_rsp_if.sv
interface ptt_rsp_if;

    logic                  valid;
    logic                  ready;
    ptt_pkg::rsp_item_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/ptt_slot_mem.sv
module ptt_slot_mem #(
    parameter int DEPTH  = ptt_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_W = 4
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output ptt_pkg::slot_entry_t  rd_data,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  ptt_pkg::slot_entry_t  wr_data
);

    ptt_pkg::slot_entry_t slot_mem [DEPTH];
    ptt_pkg::slot_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ptt_rem_unit.sv
module ptt_rem_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ptt_pkg::DATA_W-1:0]    dividend,
    input  logic [ptt_pkg::DATA_W-1:0]    divisor,
    output ptt_pkg::rem_rsp_t             rsp
);

    localparam int W     = ptt_pkg::DATA_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/periodic_task_timer_bank.sv
// Periodic task timer bank: a table of NUM_SLOTS periodic task slots.
// cmd (sink) takes one beat per operation: tick with an elapsed time,
// register with a period, or remove with slot_id. rsp (source) returns the
// result beats; the final beat of each operation carries last = 1.
// cmd is ready only between operations; one operation is worked at a time.
// A remove or an unused code goes straight to its final beat. A register
// scans the slots in order for the first free one. A tick walks every slot,
// reads each occupied one, and hands each due slot of nonzero period to the
// remainder unit, which works one bit per cycle over D = 32 steps; a due
// slot of period 0 fires without it.
// Period and elapsed count live in a single-port-read slot memory; the
// in-use bits are flip-flops. A tick reports at most 16 firings, but all
// due slots still update.
// Reset clears the in-use bits and control state; no clearing pass runs.
// A stalled rsp holds the walk only when a second firing beat is ready;
// the next cmd beat is taken while the last result beat still waits.
module periodic_task_timer_bank #(
    parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ptt_cmd_if.sink   cmd,
    ptt_rsp_if.source rsp
);

    localparam int W      = ptt_pkg::DATA_W;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int FIRE_W = ptt_pkg::FIRE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_TSCAN,
        S_TRD,
        S_TDIV,
        S_TFIRE,
        S_FINAL
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             op_reg, op_next;
    logic [W-1:0]           elapsed_reg, elapsed_next;
    logic [W-1:0]           period_reg, period_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]   in_use_reg, in_use_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [3:0]             pend_idx_reg, pend_idx_next;
    logic [FIRE_W-1:0]      fire_cnt_reg, fire_cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    ptt_pkg::rsp_item_t     rsp_reg, rsp_next;
    ptt_pkg::rsp_item_t     final_reg, final_next;

    logic                   cmd_acc;
    logic                   out_free;
    logic                   idx_end;
    logic [SLOT_W-1:0]      idx_slot;
    logic [SLOT_W+3:0]      slot_ext;
    logic [3:0]             idx4;
    logic [SLOT_W+3:0]      id_ext;
    logic [SLOT_W-1:0]      id_slot;
    logic                   id_hit;
    logic [W-1:0]           sum;

    logic                   rd_en;
    ptt_pkg::slot_entry_t   rd_data;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    ptt_pkg::slot_entry_t   wr_data;
    logic                   div_start;
    ptt_pkg::rem_rsp_t      rem_rsp;

    ptt_slot_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (idx_slot),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ptt_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .divisor  (rd_data.period),
        .rsp      (rem_rsp)
    );

    assign cmd_acc  = cmd.valid && cmd.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign idx_end  = (idx_reg == CNT_W'(NUM_SLOTS));
    assign idx_slot = idx_reg[SLOT_W-1:0];
    assign slot_ext = (SLOT_W + 4)'(idx_slot);
    assign idx4     = slot_ext[3:0];
    assign id_ext   = (SLOT_W + 4)'(cmd.payload.slot_id);
    assign id_slot  = id_ext[SLOT_W-1:0];
    assign id_hit   = (32'(cmd.payload.slot_id) < 32'(NUM_SLOTS)) && in_use_reg[id_slot];
    assign sum      = rd_data.accum + elapsed_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        elapsed_next    = elapsed_reg;
        period_next     = period_reg;
        idx_next        = idx_reg;
        in_use_next     = in_use_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_next        = rsp_reg;
        final_next      = final_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_slot;
        wr_data         = '0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the beat and dispatch on operation
                if (cmd_acc)
                begin
                    op_next       = cmd.payload.operation;
                    elapsed_next  = cmd.payload.tick_delta;
                    period_next   = cmd.payload.task_period;
                    idx_next      = '0;
                    fire_cnt_next = '0;
                    unique case (cmd.payload.operation)
                        ptt_pkg::OP_TICK:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = S_TSCAN;
                        end
                        ptt_pkg::OP_REGISTER:
                        begin
                            state_next = S_FIND;
                        end
                        ptt_pkg::OP_REMOVE:
                        begin
                            if (id_hit)
                            begin
                                in_use_next[id_slot] = 1'b0;
                                wr_en                = 1'b1;
                                wr_addr              = id_slot;
                                final_next           = '{ptt_pkg::ST_OK,
                                    cmd.payload.slot_id, 1'b0, 1'b1};
                            end
                            else
                            begin
                                final_next = '{ptt_pkg::ST_NOT_FOUND,
                                    cmd.payload.slot_id, 1'b0, 1'b1};
                            end
                            state_next = S_FINAL;
                        end
                        default:
                        begin
                            final_next = '{ptt_pkg::ST_OK, 4'd0, 1'b0, 1'b1};
                            state_next = S_FINAL;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                // Scan for the lowest free slot
                if (idx_end)
                begin
                    final_next = '{ptt_pkg::ST_CAPACITY, 4'd0, 1'b0, 1'b1};
                    state_next = S_FINAL;
                end
                else if (!in_use_reg[idx_slot])
                begin
                    in_use_next[idx_slot] = 1'b1;
                    wr_en                 = 1'b1;
                    wr_data               = '{period_reg, {W{1'b0}}};
                    final_next            = '{ptt_pkg::ST_OK, idx4, 1'b0, 1'b1};
                    state_next            = S_FINAL;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_TSCAN:
            begin
                // Walk occupied slots; close the tick at the end
                if (idx_end)
                begin
                    if (pend_valid_reg)
                    begin
                        final_next = '{ptt_pkg::ST_OK, pend_idx_reg, 1'b1, 1'b1};
                    end
                    else
                    begin
                        final_next = '{ptt_pkg::ST_OK, 4'd0, 1'b0, 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_FINAL;
                end
                else if (in_use_reg[idx_slot])
                begin
                    rd_en      = 1'b1;
                    state_next = S_TRD;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_TRD:
            begin
                // Advance the count; hand due slots of nonzero period to the remainder unit
                if (rd_data.period == '0)
                begin
                    state_next = S_TFIRE;
                end
                else if (sum >= rd_data.period)
                begin
                    div_start  = 1'b1;
                    state_next = S_TDIV;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{rd_data.period, sum};
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_TSCAN;
                end
            end

            S_TDIV:
            begin
                // Write back the coalesced count
                if (rem_rsp.done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{rd_data.period, rem_rsp.remainder};
                    state_next = S_TFIRE;
                end
            end

            S_TFIRE:
            begin
                // Hold one firing back so the final one can carry last; stop reporting at the limit
                if (fire_cnt_reg == FIRE_W'(ptt_pkg::MAX_RESULTS))
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_TSCAN;
                end
                else if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx4;
                    fire_cnt_next   = fire_cnt_reg + FIRE_W'(1);
                    idx_next        = idx_reg + CNT_W'(1);
                    state_next      = S_TSCAN;
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{ptt_pkg::ST_OK, pend_idx_reg, 1'b1, 1'b0};
                    pend_idx_next  = idx4;
                    fire_cnt_next  = fire_cnt_reg + FIRE_W'(1);
                    idx_next       = idx_reg + CNT_W'(1);
                    state_next     = S_TSCAN;
                end
            end

            S_FINAL:
            begin
                // Send the closing beat once the output register frees
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = final_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            elapsed_reg    <= '0;
            period_reg     <= '0;
            idx_reg        <= '0;
            in_use_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            fire_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            final_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            elapsed_reg    <= elapsed_next;
            period_reg     <= period_next;
            idx_reg        <= idx_next;
            in_use_reg     <= in_use_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            fire_cnt_reg   <= fire_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
            final_reg      <= final_next;
        end
    end

    assign cmd.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // An accepted beat always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> state_reg != S_IDLE)
        else $error("accepted beat left the sequencer idle");

    // The remainder unit answers only while the walk waits for it
    a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> state_reg == S_TDIV)
        else $error("remainder result outside the divide wait");

    // Reported firings never pass the result limit
    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_W'(ptt_pkg::MAX_RESULTS))
        else $error("firing count beyond the result limit");

    // A held-back firing belongs to a tick
    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> op_reg == ptt_pkg::OP_TICK)
        else $error("pending firing outside a tick");

    // A non-final beat only waits while its tick is still open
    a_open_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.last) |->
            (state_reg == S_TSCAN || state_reg == S_TRD || state_reg == S_TDIV ||
             state_reg == S_TFIRE || state_reg == S_FINAL))
        else $error("non-final beat outside an open tick");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM        = ptt_pkg::NUM_SLOTS_DEF;
    localparam int LONG_HOLD  = 500;
    localparam int DRAIN_WAIT = 700;
    localparam int RANDOM_CMDS = 95;

    // Spare operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Shadow of the slot table; holds the result beats still owed by the block
    class timer_table_shadow;
        bit                         in_use [NUM];
        logic [ptt_pkg::DATA_W-1:0] period [NUM];
        logic [ptt_pkg::DATA_W-1:0] accum  [NUM];
        ptt_pkg::rsp_item_t         awaited_beats[$];
        int                         failures;
        int                         n_tick, n_register, n_remove, n_unused;
        int                         n_fired, n_full, n_missing;

        function new();
            for (int i = 0; i < NUM; i++)
            begin
                in_use[i] = 1'b0;
                period[i] = '0;
                accum[i]  = '0;
            end
        endfunction

        function int slots_used();
            int cnt;
            cnt = 0;
            for (int i = 0; i < NUM; i++)
                cnt += in_use[i];
            return cnt;
        endfunction

        function ptt_pkg::rsp_item_t result_beat(logic [1:0] st, logic [3:0] idx,
                                                 logic fire, logic fin);
            ptt_pkg::rsp_item_t r;
            r.status     = st;
            r.slot_index = idx;
            r.fired      = fire;
            r.last       = fin;
            return r;
        endfunction

        // Advance the table by one accepted command and queue its result beats
        function void note_command(ptt_pkg::cmd_item_t c);
            bit                         fire_mask [NUM];
            int                         last_fire;
            int                         free_slot;
            int                         reported;
            logic [ptt_pkg::DATA_W-1:0] sum;
            last_fire = -1;
            free_slot = -1;
            reported  = 0;
            case (c.operation)
                ptt_pkg::OP_TICK:
                begin
                    n_tick++;
                    for (int i = 0; i < NUM; i++)
                    begin
                        fire_mask[i] = 1'b0;
                        if (in_use[i])
                        begin
                            if (period[i] == '0)
                                fire_mask[i] = 1'b1;
                            else
                            begin
                                sum = accum[i] + c.tick_delta;
                                if (sum >= period[i])
                                begin
                                    sum = sum % period[i];
                                    fire_mask[i] = 1'b1;
                                end
                                accum[i] = sum;
                            end
                        end
                        if (fire_mask[i] && reported < ptt_pkg::MAX_RESULTS)
                        begin
                            last_fire = i;
                            reported++;
                        end
                    end
                    if (last_fire < 0)
                        awaited_beats.push_back(result_beat(ptt_pkg::ST_OK, 4'd0, 1'b0,
                                                            1'b1));
                    else
                    begin
                        reported = 0;
                        for (int i = 0; i <= last_fire; i++)
                        begin
                            if (fire_mask[i] && reported < ptt_pkg::MAX_RESULTS)
                            begin
                                awaited_beats.push_back(result_beat(ptt_pkg::ST_OK, i[3:0],
                                                                    1'b1, i == last_fire));
                                reported++;
                                n_fired++;
                            end
                        end
                    end
                end
                ptt_pkg::OP_REGISTER:
                begin
                    n_register++;
                    for (int i = NUM - 1; i >= 0; i--)
                        if (!in_use[i])
                            free_slot = i;
                    if (free_slot < 0)
                    begin
                        n_full++;
                        awaited_beats.push_back(result_beat(ptt_pkg::ST_CAPACITY, 4'd0, 1'b0,
                                                            1'b1));
                    end
                    else
                    begin
                        in_use[free_slot] = 1'b1;
                        period[free_slot] = c.task_period;
                        accum[free_slot]  = '0;
                        awaited_beats.push_back(result_beat(ptt_pkg::ST_OK, free_slot[3:0],
                                                            1'b0, 1'b1));
                    end
                end
                ptt_pkg::OP_REMOVE:
                begin
                    n_remove++;
                    if (int'(c.slot_id) >= NUM || !in_use[c.slot_id])
                    begin
                        n_missing++;
                        awaited_beats.push_back(result_beat(ptt_pkg::ST_NOT_FOUND, c.slot_id,
                                                            1'b0, 1'b1));
                    end
                    else
                    begin
                        in_use[c.slot_id] = 1'b0;
                        period[c.slot_id] = '0;
                        accum[c.slot_id]  = '0;
                        awaited_beats.push_back(result_beat(ptt_pkg::ST_OK, c.slot_id, 1'b0,
                                                            1'b1));
                    end
                end
                default:
                begin
                    n_unused++;
                    awaited_beats.push_back(result_beat(ptt_pkg::ST_OK, 4'd0, 1'b0, 1'b1));
                end
            endcase
        endfunction

        // Compare one result beat against the oldest owed beat
        function void check_beat(ptt_pkg::rsp_item_t got);
            ptt_pkg::rsp_item_t exp;
            if (awaited_beats.size() == 0)
            begin
                if (failures < 10)
                    $display("[%0t] unexpected beat: status=%0d slot=%0d fired=%0b last=%0b",
                             $realtime, got.status, got.slot_index, got.fired, got.last);
                failures++;
                return;
            end
            exp = awaited_beats.pop_front();
            if (got.status !== exp.status || got.slot_index !== exp.slot_index ||
                got.fired !== exp.fired || got.last !== exp.last)
            begin
                if (failures < 10)
                begin
                    $display("[%0t] beat mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                             $realtime, exp.status, got.status, exp.slot_index,
                             got.slot_index);
                    $display("    fired exp %0b got %0b, last exp %0b got %0b",
                             exp.fired, got.fired, exp.last, got.last);
                end
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ptt_cmd_if cmd_ch ();
    ptt_rsp_if rsp_ch ();

    timer_table_shadow table_shadow = new();

    int burst_left = 1;
    int holds_requested = 0;
    int holds_done = 0;
    int hold_left = 0;
    int rx_cycle = 0;

    periodic_task_timer_bank u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Receiver: check accepted beats, stall on a rotating pattern, honor long holds
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                table_shadow.check_beat(rsp_ch.payload);
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (holds_requested > holds_done)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 64) % 4)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: rsp_ch.ready <= (rx_cycle % 3 == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Offer one command beat, wait for acceptance, then maybe pause between bursts
    task automatic offer_command(input ptt_pkg::cmd_item_t c);
        int gap;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        table_shadow.note_command(c);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic issue(input logic [1:0] op, input logic [31:0] elapsed,
                         input logic [31:0] per, input logic [3:0] id);
        ptt_pkg::cmd_item_t c;
        c.operation   = op;
        c.tick_delta  = elapsed;
        c.task_period = per;
        c.slot_id     = id;
        offer_command(c);
    endtask

    // Build a random command, biased toward small periods and elapsed times
    function automatic ptt_pkg::cmd_item_t random_command();
        ptt_pkg::cmd_item_t c;
        int                 pick;
        int                 used;
        int                 nth;
        pick          = $urandom_range(0, 99);
        used          = table_shadow.slots_used();
        c.tick_delta  = $urandom;
        c.task_period = $urandom;
        c.slot_id     = 4'($urandom_range(0, 15));
        if (pick < 45)
        begin
            c.operation = ptt_pkg::OP_TICK;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                c.tick_delta = '0;
            else if (pick < 75)
                c.tick_delta = $urandom_range(1, 25);
            else if (pick < 90)
                c.tick_delta = $urandom_range(26, 500);
        end
        else if (pick < 72 && used < NUM - 1 || pick < 55)
        begin
            c.operation = ptt_pkg::OP_REGISTER;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                c.task_period = '0;
            else if (pick < 70)
                c.task_period = $urandom_range(1, 40);
            else if (pick < 85)
                c.task_period = $urandom_range(41, 1000);
        end
        else if (pick < 95)
        begin
            c.operation = ptt_pkg::OP_REMOVE;
            if ($urandom_range(0, 99) < 70 && used > 0)
            begin
                nth = $urandom_range(0, used - 1);
                for (int i = 0; i < NUM; i++)
                begin
                    if (table_shadow.in_use[i])
                    begin
                        if (nth == 0)
                            c.slot_id = i[3:0];
                        nth--;
                    end
                end
            end
        end
        else
            c.operation = OP_UNUSED;
        return c;
    endfunction

    initial
    begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        rst_n          = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, unknown slot, ignored code
        issue(ptt_pkg::OP_TICK, 32'd5, 32'd0, 4'd0);
        issue(ptt_pkg::OP_REMOVE, 32'd0, 32'd0, 4'd3);
        issue(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);

        // Fill every slot, with period extremes, then overflow the table
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd0, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd1, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'hFFFF_FFFF, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'h8000_0000, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd2, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd3, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd5, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd7, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd10, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd100, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd0, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd1, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd1000, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'h7FFF_FFFF, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd4, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd6, 4'd0);
        issue(ptt_pkg::OP_REGISTER, 32'd0, 32'd9, 4'd0);

        // Ticks: zero elapsed, full wrap (every slot due), then wrap with residue
        issue(ptt_pkg::OP_TICK, 32'd0, 32'd0, 4'd0);
        issue(ptt_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 4'd0);
        issue(ptt_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 4'd0);

        // Free the top slot, then try it again
        issue(ptt_pkg::OP_REMOVE, 32'd0, 32'd0, 4'd15);
        issue(ptt_pkg::OP_REMOVE, 32'd0, 32'd0, 4'd15);

        // Random traffic with two long receiver holds along the way
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n == 10 || n == 70)
                holds_requested++;
            offer_command(random_command());
        end
        cmd_ch.valid <= 1'b0;

        // Drain owed beats, then idle for one worst-case tick
        while (table_shadow.awaited_beats.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (table_shadow.awaited_beats.size() > 0)
        begin
            $display("%0d result beats never arrived", table_shadow.awaited_beats.size());
            table_shadow.failures += table_shadow.awaited_beats.size();
        end
        $display("Ran %0d ticks, %0d registers, %0d removes, %0d ignored codes",
                 table_shadow.n_tick, table_shadow.n_register, table_shadow.n_remove,
                 table_shadow.n_unused);
        $display("Saw %0d firing beats, %0d table-full and %0d not-found replies; %0d failures",
                 table_shadow.n_fired, table_shadow.n_full, table_shadow.n_missing,
                 table_shadow.failures);
        if (table_shadow.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #5_000_000;
        $display("Timeout waiting for the block");
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/ptt_pkg.sv
rtl/ptt_cmd_if.sv
rtl/ptt_rsp_if.sv
rtl/ptt_slot_mem.sv
rtl/ptt_rem_unit.sv
rtl/periodic_task_timer_bank.sv
test/tb_top.sv
